// File: sv/csd_pkg.sv
package csd_pkg;

  localparam int ID_W     = 8;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_PICK   = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // control from the sequencer to the candidate selector
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

// File: sv/csd_req_if.sv
interface csd_req_if #(
  parameter int TRACK_W = 10,
  parameter int BLOCK_W = 5
);
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [csd_pkg::ID_W-1:0] req_id;
  logic [TRACK_W-1:0]       track;
  logic [BLOCK_W-1:0]       blocks;

  modport source (output valid, op, req_id, track, blocks, input ready);
  modport sink   (input valid, op, req_id, track, blocks, output ready);
endinterface

// File: sv/csd_rsp_if.sv
interface csd_rsp_if #(
  parameter int TRACK_W = 10,
  parameter int BLOCK_W = 5
);
  logic                         valid;
  logic                         ready;
  logic [csd_pkg::STATUS_W-1:0] status;
  logic                         granted;
  logic [csd_pkg::ID_W-1:0]     out_id;
  logic [TRACK_W-1:0]           out_track;
  logic [BLOCK_W-1:0]           out_blocks;

  modport source (output valid, status, granted, out_id, out_track, out_blocks,
                  input ready);
  modport sink   (input valid, status, granted, out_id, out_track, out_blocks,
                  output ready);
endinterface

// File: sv/csd_table_mem.sv
module csd_table_mem #(
  parameter int DEPTH = 16,
  parameter int DW    = 27,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/csd_select.sv
module csd_select #(
  parameter int IDX_W = 4,
  parameter int TW    = 10,
  parameter int AW    = 4,
  parameter int HW    = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  csd_pkg::scan_ctl_t ctl,
  input  logic [IDX_W-1:0]   idx,
  input  logic [TW-1:0]      trk,
  input  logic [AW-1:0]      age,
  input  logic [HW-1:0]      head,
  input  logic               head_known,
  output logic               found,
  output logic [IDX_W-1:0]   pick
);

  logic             above_ok;
  logic [IDX_W-1:0] old_idx, ab_idx, lo_idx;
  logic [AW-1:0]    old_age, ab_age, lo_age;
  logic [TW-1:0]    ab_trk, lo_trk;

  logic is_above, take_old, take_ab, take_lo;

  always_comb begin
    is_above = HW'(trk) > head;
    take_old = !found || age > old_age;
    // equal track: smaller age means newer, which wins
    take_ab  = is_above &&
               (!above_ok || trk < ab_trk || (trk == ab_trk && age < ab_age));
    take_lo  = !found || trk < lo_trk || (trk == lo_trk && age < lo_age);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found    <= 1'b0;
      above_ok <= 1'b0;
    end else if (ctl.sample) begin
      found <= 1'b1;
      if (take_old) begin
        old_idx <= idx;
        old_age <= age;
      end
      if (take_ab) begin
        above_ok <= 1'b1;
        ab_idx   <= idx;
        ab_trk   <= trk;
        ab_age   <= age;
      end
      if (take_lo) begin
        lo_idx <= idx;
        lo_trk <= trk;
        lo_age <= age;
      end
    end
  end

  assign pick = !head_known ? old_idx : (above_ok ? ab_idx : lo_idx);

endmodule

// File: sv/disk_request_cscan_scheduler_core.sv
// C-SCAN pending-request table for one disk unit. An insert stores id, track
// and block count in the first free slot (status full when none is free); a
// pick returns the oldest request until a head position exists, then the
// nearest track above the head, else the lowest track, newest request on a
// tie, and moves the head to track + blocks - 1. Entries sit in a synchronous
// RAM with one read and one write port that the sequencer sweeps one entry per
// cycle. An insert runs an age sweep over the stored entries, then writes the new
// one; a pick runs a selection sweep, re-reads the winner and runs an age fix-up
// sweep; a full insert or empty pick goes straight to the response. The next
// request can be taken in the same cycle as the response is offered, while that
// response may still wait; a response held back by the receiver holds up the one behind it.
module disk_request_cscan_scheduler_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int MAX_BLOCKS  = 16,
  parameter int TRACK_COUNT = 1024
) (
  input logic      clk,
  input logic      rst,
  csd_req_if.sink  req,
  csd_rsp_if.source rsp
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int AW    = IDX_W;
  localparam int TW    = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int BW    = $clog2(MAX_BLOCKS + 1);
  localparam int HW    = ((TW > BW) ? TW : BW) + 1;
  localparam int DW    = csd_pkg::ID_W + TW + BW + AW;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_INS_SCAN  = 8'b0000_0010,
    S_INS_WRITE = 8'b0000_0100,
    S_PICK_SCAN = 8'b0000_1000,
    S_PICK_READ = 8'b0001_0000,
    S_PICK_GET  = 8'b0010_0000,
    S_PICK_DEC  = 8'b0100_0000,
    S_RESP      = 8'b1000_0000
  } state_t;

  state_t state;

  logic [TABLE_DEPTH-1:0]   valid;
  logic [IDX_W:0]           cnt;
  logic                     rd_act;
  logic [IDX_W-1:0]         rd_idx;
  logic [IDX_W-1:0]         slot;
  logic [HW-1:0]            head;
  logic                     head_known;
  logic [AW-1:0]            pick_age;
  logic [csd_pkg::ID_W-1:0] in_id;
  logic [TW-1:0]            in_trk;
  logic [BW-1:0]            in_blk;

  logic [csd_pkg::STATUS_W-1:0] pend_status;
  logic                         pend_granted;
  logic [csd_pkg::ID_W-1:0]     pend_id;
  logic [TW-1:0]                pend_track;
  logic [BW-1:0]                pend_blocks;

  logic                         out_valid;
  logic [csd_pkg::STATUS_W-1:0] out_status;
  logic                         out_granted;
  logic [csd_pkg::ID_W-1:0]     out_id;
  logic [TW-1:0]                out_track;
  logic [BW-1:0]                out_blocks;

  // memory ports
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0]    mem_wdata, mem_rdata;

  logic [csd_pkg::ID_W-1:0] w_id;
  logic [TW-1:0]            w_trk;
  logic [BW-1:0]            w_cnt;
  logic [AW-1:0]            w_age;

  logic               scan_state, scan_issue, scan_done, hit, full, empty;
  logic [IDX_W-1:0]   free_slot, pick;
  logic               found;
  logic [HW-1:0]      end_sum;
  csd_pkg::scan_ctl_t ctl;

  assign w_id  = mem_rdata[DW-1 -: csd_pkg::ID_W];
  assign w_trk = mem_rdata[AW+BW +: TW];
  assign w_cnt = mem_rdata[AW +: BW];
  assign w_age = mem_rdata[AW-1:0];

  assign full  = &valid;
  assign empty = ~|valid;

  always_comb begin
    free_slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) free_slot = IDX_W'(i);
    end
  end

  assign scan_state = (state == S_INS_SCAN) || (state == S_PICK_SCAN) ||
                      (state == S_PICK_DEC);
  assign scan_issue = scan_state && (cnt < (IDX_W + 1)'(TABLE_DEPTH));
  assign scan_done  = !scan_issue && !rd_act;
  assign hit        = rd_act && valid[rd_idx];
  assign end_sum    = HW'(w_trk) + HW'(w_cnt);

  always_comb begin
    mem_re    = scan_issue || (state == S_PICK_READ);
    mem_raddr = (state == S_PICK_READ) ? pick : cnt[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = {w_id, w_trk, w_cnt, w_age};
    case (state)
      S_INS_SCAN: begin
        mem_we    = hit;
        mem_wdata = {w_id, w_trk, w_cnt, w_age + AW'(1)};
      end
      S_INS_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = slot;
        mem_wdata = {in_id, in_trk, in_blk, AW'(0)};
      end
      S_PICK_DEC: begin
        // close the gap left by the removed entry
        mem_we    = hit && (w_age > pick_age);
        mem_wdata = {w_id, w_trk, w_cnt, w_age - AW'(1)};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign ctl.clear  = (state == S_IDLE) && req.valid &&
                      (req.op == csd_pkg::OP_PICK);
  assign ctl.sample = (state == S_PICK_SCAN) && hit;

  csd_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .DW    (DW),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  csd_select #(
    .IDX_W (IDX_W),
    .TW    (TW),
    .AW    (AW),
    .HW    (HW)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .idx        (rd_idx),
    .trk        (w_trk),
    .age        (w_age),
    .head       (head),
    .head_known (head_known),
    .found      (found),
    .pick       (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      rd_act     <= 1'b0;
      cnt        <= '0;
      head       <= '0;
      head_known <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((state != S_RESP) && out_valid && rsp.ready) out_valid <= 1'b0;

      if (scan_state) begin
        rd_act <= scan_issue;
        rd_idx <= cnt[IDX_W-1:0];
        if (scan_issue) cnt <= cnt + 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            in_id        <= req.req_id;
            in_trk       <= req.track;
            in_blk       <= req.blocks;
            cnt          <= '0;
            rd_act       <= 1'b0;
            pend_granted <= 1'b0;
            pend_id      <= '0;
            pend_track   <= '0;
            pend_blocks  <= '0;
            if (req.op == csd_pkg::OP_INSERT) begin
              if (full) begin
                pend_status <= csd_pkg::ST_FULL;
                state       <= S_RESP;
              end else begin
                slot  <= free_slot;
                state <= S_INS_SCAN;
              end
            end else begin
              if (empty) begin
                pend_status <= csd_pkg::ST_EMPTY;
                state       <= S_RESP;
              end else begin
                state <= S_PICK_SCAN;
              end
            end
          end
        end
        S_INS_SCAN: begin
          if (scan_done) state <= S_INS_WRITE;
        end
        S_INS_WRITE: begin
          valid[slot] <= 1'b1;
          pend_status <= csd_pkg::ST_OK;
          state       <= S_RESP;
        end
        S_PICK_SCAN: begin
          if (scan_done) state <= S_PICK_READ;
        end
        S_PICK_READ: begin
          state <= S_PICK_GET;
        end
        S_PICK_GET: begin
          pend_status  <= csd_pkg::ST_OK;
          pend_granted <= found;
          pend_id      <= w_id;
          pend_track   <= w_trk;
          pend_blocks  <= w_cnt;
          pick_age     <= w_age;
          valid[pick]  <= 1'b0;
          head         <= (end_sum == '0) ? '0 : end_sum - 1'b1;
          head_known   <= 1'b1;
          cnt          <= '0;
          rd_act       <= 1'b0;
          state        <= S_PICK_DEC;
        end
        S_PICK_DEC: begin
          if (scan_done) state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_status  <= pend_status;
            out_granted <= pend_granted;
            out_id      <= pend_id;
            out_track   <= pend_track;
            out_blocks  <= pend_blocks;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.granted    = out_granted;
  assign rsp.out_id     = out_id;
  assign rsp.out_track  = out_track;
  assign rsp.out_blocks = out_blocks;

endmodule

// File: test/tb_disk_request_cscan_scheduler_core.sv
`timescale 1ns / 1ps

module tb_disk_request_cscan_scheduler_core;

  localparam int TRACK_W      = 10;
  localparam int BLOCK_W      = 5;
  localparam int HEAD_W       = 11;
  localparam int ID_W         = csd_pkg::ID_W;
  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    csd_pkg::op_t       op;
    logic [ID_W-1:0]    id;
    logic [TRACK_W-1:0] track;
    logic [BLOCK_W-1:0] blocks;
  } request_t;

  typedef struct packed {
    csd_pkg::status_t   status;
    logic               granted;
    logic [ID_W-1:0]    id;
    logic [TRACK_W-1:0] track;
    logic [BLOCK_W-1:0] blocks;
  } reply_t;

  typedef struct packed {
    bit     fixed;
    reply_t r;
  } typed_reply_t;

  typedef struct {
    request_t     req;
    int           reps;
    typed_reply_t want;
  } plan_row_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_style_t;

  logic clk;
  logic rst;

  csd_req_if #(.TRACK_W(TRACK_W), .BLOCK_W(BLOCK_W)) req_bus ();
  csd_rsp_if #(.TRACK_W(TRACK_W), .BLOCK_W(BLOCK_W)) rsp_bus ();

  disk_request_cscan_scheduler_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // mirror of the pending-request table
  logic               slot_used   [SLOTS];
  logic [ID_W-1:0]    slot_id     [SLOTS];
  logic [TRACK_W-1:0] slot_track  [SLOTS];
  logic [BLOCK_W-1:0] slot_blocks [SLOTS];
  logic [3:0]         slot_rank   [SLOTS];
  logic [HEAD_W-1:0]  head_pos;
  logic               head_set;

  reply_t       scheduler_replies [$];
  typed_reply_t typed_replies     [$];

  int           mismatches = 0;
  int           idle_cycles;
  int           burst_left;
  int           hold_left;
  int           style_timer;
  stall_style_t stall_style;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got 'h%0h, expected 'h%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // C-SCAN decision for one request, updating the mirrored table
  task automatic cscan_schedule(input request_t it, output reply_t r);
    int free_slot;
    int oldest;
    int above;
    int lowest;
    int pick;
    logic [3:0] rank;
    logic [HEAD_W:0] end_pos;
    r = '0;
    r.status = csd_pkg::ST_OK;
    if (it.op == csd_pkg::OP_INSERT) begin
      free_slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!slot_used[i]) free_slot = i;
      if (free_slot < 0) begin
        r.status = csd_pkg::ST_FULL;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i]) slot_rank[i] = slot_rank[i] + 4'd1;
        slot_used[free_slot]   = 1'b1;
        slot_id[free_slot]     = it.id;
        slot_track[free_slot]  = it.track;
        slot_blocks[free_slot] = it.blocks;
        slot_rank[free_slot]   = 4'd0;
      end
    end else begin
      oldest = -1;
      above  = -1;
      lowest = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) begin
          if (oldest < 0 || slot_rank[i] > slot_rank[oldest]) oldest = i;
          if ({1'b0, slot_track[i]} > head_pos) begin
            if (above < 0 || slot_track[i] < slot_track[above] ||
                (slot_track[i] == slot_track[above] && slot_rank[i] < slot_rank[above]))
              above = i;
          end
          if (lowest < 0 || slot_track[i] < slot_track[lowest] ||
              (slot_track[i] == slot_track[lowest] && slot_rank[i] < slot_rank[lowest]))
            lowest = i;
        end
      end
      if (oldest < 0) begin
        r.status = csd_pkg::ST_EMPTY;
      end else begin
        pick = !head_set ? oldest : (above >= 0 ? above : lowest);
        rank = slot_rank[pick];
        slot_used[pick] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && slot_rank[i] > rank) slot_rank[i] = slot_rank[i] - 4'd1;
        end_pos  = {2'b0, slot_track[pick]} + {7'b0, slot_blocks[pick]};
        // track 0 with no blocks leaves the head at 0 rather than below it
        head_pos = (end_pos == '0) ? '0 : HEAD_W'(end_pos - 1'b1);
        head_set = 1'b1;
        r.granted = 1'b1;
        r.id      = slot_id[pick];
        r.track   = slot_track[pick];
        r.blocks  = slot_blocks[pick];
      end
    end
  endtask

  function automatic plan_row_t plan_row(input csd_pkg::op_t op,
                                         input logic [ID_W-1:0] id,
                                         input logic [TRACK_W-1:0] track,
                                         input logic [BLOCK_W-1:0] blocks, input int reps,
                                         input bit fixed, input csd_pkg::status_t st,
                                         input logic g, input logic [ID_W-1:0] oid,
                                         input logic [TRACK_W-1:0] otr,
                                         input logic [BLOCK_W-1:0] obl);
    plan_row_t row;
    row.req  = '{op, id, track, blocks};
    row.reps = reps;
    row.want = '{fixed, '{st, g, oid, otr, obl}};
    return row;
  endfunction

  // sender: bursts of back-to-back transactions separated by random gaps
  task automatic offer_request(input request_t it, input typed_reply_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    typed_replies.push_back(want);
    req_bus.valid  <= 1'b1;
    req_bus.op     <= it.op;
    req_bus.req_id <= it.id;
    req_bus.track  <= it.track;
    req_bus.blocks <= it.blocks;
    do @(posedge clk); while (!req_bus.ready);
    burst_left--;
  endtask

  // accepted requests feed the predictor
  always @(posedge clk) begin
    request_t     it;
    reply_t       r;
    typed_reply_t t;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      head_pos = '0;
      head_set = 1'b0;
    end else if (req_bus.valid && req_bus.ready) begin
      it.op     = csd_pkg::op_t'(req_bus.op);
      it.id     = req_bus.req_id;
      it.track  = req_bus.track;
      it.blocks = req_bus.blocks;
      cscan_schedule(it, r);
      t = typed_replies.pop_front();
      scheduler_replies.push_back(t.fixed ? t.r : r);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (scheduler_replies.size() == 0) begin
        note_mismatch("reply with nothing due", 32'(rsp_bus.status), 32'd0);
      end else begin
        want = scheduler_replies.pop_front();
        if (rsp_bus.status !== want.status)
          note_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
        if (rsp_bus.granted !== want.granted)
          note_mismatch("granted", 32'(rsp_bus.granted), 32'(want.granted));
        if (rsp_bus.out_id !== want.id)
          note_mismatch("out_id", 32'(rsp_bus.out_id), 32'(want.id));
        if (rsp_bus.out_track !== want.track)
          note_mismatch("out_track", 32'(rsp_bus.out_track), 32'(want.track));
        if (rsp_bus.out_blocks !== want.blocks)
          note_mismatch("out_blocks", 32'(rsp_bus.out_blocks), 32'(want.blocks));
      end
    end
  end

  // receiver back-pressure; the stall style is redrawn each time style_timer wraps
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= 0;
      style_timer   <= 0;
      stall_style   <= STALL_NONE;
    end else begin
      if (hold_left != 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else begin
        rsp_bus.ready <= 1'b1;
        case (stall_style)
          STALL_LIGHT: if ($urandom_range(3) == 0) hold_left <= $urandom_range(3, 1);
          STALL_HEAVY: if ($urandom_range(15) == 0) hold_left <= $urandom_range(30, 8);
          default: ;
        endcase
      end
      style_timer <= style_timer + 1;
      if (style_timer == 255) begin
        style_timer <= 0;
        stall_style <= stall_style_t'($urandom_range(2));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[disk_request_cscan_scheduler_core] ERROR");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    plan_row_t row;
    request_t  it;
    logic [TRACK_W-1:0] tie_tracks [8];
    int phase_left;
    int insert_pct;

    tie_tracks = '{10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd513, 10'd1022, 10'd1023};
    burst_left = 0;

    rst            <= 1'b1;
    req_bus.valid  <= 1'b0;
    req_bus.op     <= csd_pkg::OP_INSERT;
    req_bus.req_id <= '0;
    req_bus.track  <= '0;
    req_bus.blocks <= '0;

    // empty pick, extremes, oldest-first before any head, ties, wrap, full table
    plan.push_back(plan_row(csd_pkg::OP_PICK, 8'h00, 10'd0, 5'd0, 1, 1'b1,
                            csd_pkg::ST_EMPTY, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'h00, 10'd0, 5'd1, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'hFF, 10'd1023, 5'd16, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'h5A, 10'd512, 5'd0, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'hA5, 10'd512, 5'd31, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_PICK, 8'h00, 10'd0, 5'd0, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b1, 8'h00, 10'd0, 5'd1));
    plan.push_back(plan_row(csd_pkg::OP_PICK, 8'h00, 10'd0, 5'd0, 3, 1'b0,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_PICK, 8'h00, 10'd0, 5'd0, 1, 1'b1,
                            csd_pkg::ST_EMPTY, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'h11, 10'd0, 5'd0, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_PICK, 8'h00, 10'd0, 5'd0, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b1, 8'h11, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'h22, 10'd0, 5'd5, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'h33, 10'd1, 5'd2, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_PICK, 8'h00, 10'd0, 5'd0, 2, 1'b0,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'h40, 10'd100, 5'd3, SLOTS, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'hEE, 10'd7, 5'd7, 1, 1'b1,
                            csd_pkg::ST_FULL, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_PICK, 8'h00, 10'd0, 5'd0, 1, 1'b0,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_INSERT, 8'hEF, 10'd1023, 5'd31, 1, 1'b1,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));
    plan.push_back(plan_row(csd_pkg::OP_PICK, 8'h00, 10'd0, 5'd0, 1, 1'b0,
                            csd_pkg::ST_OK, 1'b0, 8'h00, 10'd0, 5'd0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      row = plan[n];
      for (int k = 0; k < row.reps; k++) begin
        it        = row.req;
        it.id     = row.req.id + ID_W'(k);
        it.track  = row.req.track + TRACK_W'(k * 61);
        offer_request(it, row.want);
      end
    end

    // random part: phases lean towards filling or draining the table, or neither
    phase_left = 0;
    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(70, 30);
        case ($urandom_range(2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      phase_left--;
      it.op = ($urandom_range(99) < insert_pct) ? csd_pkg::OP_INSERT : csd_pkg::OP_PICK;
      it.id = ID_W'($urandom_range(255));
      if ($urandom_range(9) < 3)
        it.track = tie_tracks[$urandom_range(7)];
      else
        it.track = TRACK_W'($urandom_range(1023));
      if ($urandom_range(19) < 17)
        it.blocks = BLOCK_W'($urandom_range(16, 1));
      else
        it.blocks = BLOCK_W'($urandom_range(31, 0));
      offer_request(it, '0);
    end

    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (scheduler_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("[disk_request_cscan_scheduler_core] OK");
    else
      $display("[disk_request_cscan_scheduler_core] ERROR");
    $finish;
  end

endmodule
